// File: design/bgb_pkg.sv
// ----------------------------------------------------------------------------
// bgb_pkg
// Shared opcodes, command classes and item structs of the bit-granular buffer.
// ----------------------------------------------------------------------------
package bgb_pkg;

   // request opcodes as they arrive on the stream
   localparam logic [2:0] OPC_WRITE = 3'd0;
   localparam logic [2:0] OPC_READ  = 3'd1;
   localparam logic [2:0] OPC_CLEAR = 3'd2;
   localparam logic [2:0] OPC_PAD   = 3'd3;
   localparam logic [2:0] OPC_SKIP  = 3'd4;
   localparam logic [2:0] OPC_SEEK  = 3'd5;

   localparam int unsigned DATA_BITS  = 32;
   localparam int unsigned COUNT_BITS = 6;
   localparam int unsigned POS_BITS   = 16;

   typedef enum logic [2:0] {
      KIND_WRITE = 3'd0,
      KIND_READ  = 3'd1,
      KIND_CLEAR = 3'd2,
      KIND_PAD   = 3'd3,
      KIND_SKIP  = 3'd4,
      KIND_SEEK  = 3'd5,
      KIND_NOP   = 3'd6
   } kind_type;

   // classified command passed from front to back
   typedef struct packed {
      kind_type                kind;
      logic [DATA_BITS-1:0]    value;
      logic [COUNT_BITS-1:0]   count;   // already clamped
   } cmd_type;

   typedef struct packed {
      logic [DATA_BITS-1:0]    read_data;
      logic [COUNT_BITS-1:0]   bits_done;
      logic [POS_BITS-1:0]     cursor_now;
      logic [POS_BITS-1:0]     fill_bits;
      logic                    fault;
   } rsp_type;

endpackage

// File: design/bgb_ram.sv
// ----------------------------------------------------------------------------
// bgb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bgb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/bgb_front.sv
// ----------------------------------------------------------------------------
// bgb_front
// Accepts request items, decodes the opcode, clamps the bit count and holds
// the classified commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module bgb_front #(
   parameter int MAX_FIELD_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_opcode,
   input  logic [bgb_pkg::DATA_BITS-1:0]    req_value,
   input  logic [bgb_pkg::COUNT_BITS-1:0]   req_count,
   output logic                             cmd_valid,
   output bgb_pkg::cmd_type                 cmd,
   input  logic                             cmd_pop
);

   localparam int LIM = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;
   localparam logic [bgb_pkg::COUNT_BITS-1:0] LIM_COUNT = bgb_pkg::COUNT_BITS'(LIM);

   bgb_pkg::cmd_type   entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff,  count_in;
   bgb_pkg::cmd_type   decoded;
   logic               push;

   always_comb begin
      unique case (req_opcode)
         bgb_pkg::OPC_WRITE: decoded.kind = bgb_pkg::KIND_WRITE;
         bgb_pkg::OPC_READ:  decoded.kind = bgb_pkg::KIND_READ;
         bgb_pkg::OPC_CLEAR: decoded.kind = bgb_pkg::KIND_CLEAR;
         bgb_pkg::OPC_PAD:   decoded.kind = bgb_pkg::KIND_PAD;
         bgb_pkg::OPC_SKIP:  decoded.kind = bgb_pkg::KIND_SKIP;
         bgb_pkg::OPC_SEEK:  decoded.kind = bgb_pkg::KIND_SEEK;
         default:            decoded.kind = bgb_pkg::KIND_NOP;
      endcase
      decoded.value = req_value;
      decoded.count = (req_count > LIM_COUNT) ? LIM_COUNT : req_count;
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: design/bgb_back.sv
// ----------------------------------------------------------------------------
// bgb_back
// Executes commands against the cursor, the recorded size and the byte store.
// Field writes run a byte-wise read-modify-write, field reads gather bytes.
// ----------------------------------------------------------------------------
module bgb_back #(
   parameter int STORE_BYTES    = 4096,
   parameter int MAX_FIELD_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  bgb_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bgb_pkg::rsp_type  rsp
);

   localparam int CAP  = STORE_BYTES * 8;
   localparam int CW   = $clog2(CAP + 1);
   localparam int AW   = $clog2(STORE_BYTES);
   localparam int LIM  = (MAX_FIELD_BITS < 32) ? MAX_FIELD_BITS : 32;
   localparam int SPAN = (LIM + 14) / 8;     // bytes one field can touch
   localparam int SB   = SPAN * 8;
   localparam int KW   = $clog2(SPAN + 1);
   localparam logic [CW:0] CAP_X = (CW + 1)'(CAP);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_ACCESS = 2'b10
   } back_state_type;

   back_state_type          state_ff,   state_in;
   logic [CW-1:0]           cursor_ff,  cursor_in;
   logic [CW-1:0]           size_ff,    size_in;
   logic                    is_read_ff, is_read_in;
   logic [AW-1:0]           base_ff,    base_in;
   logic [2:0]              off_ff,     off_in;
   logic [KW-1:0]           nbytes_ff,  nbytes_in;
   logic [KW-1:0]           k_ff,       k_in;
   logic [5:0]              n_ff,       n_in;
   logic [SB-1:0]           wdata_ff,   wdata_in;
   logic [SB-1:0]           wmask_ff,   wmask_in;
   logic [SB-1:0]           buf_ff,     buf_in;
   logic                    out_valid_ff, out_valid_in;
   bgb_pkg::rsp_type        out_ff,     out_in;

   // command evaluation in idle
   logic [2:0]  gap;
   logic [5:0]  acc_n;
   logic [CW:0] end_acc;
   logic [CW:0] end_skip;
   logic        wr_fit, rd_fit, is_wr, is_rd, goes_access, load_ok;
   logic [6:0]  span_bits;
   logic [SB-1:0] nmask_cmd;

   // byte loop
   logic [KW-1:0] j;
   logic [SB-1:0] wdata_sh, wmask_sh, nmask_run;
   logic [7:0]    rbyte, wbyte, dbyte, mbyte;
   logic          rd_en, wr_en, last;
   logic [AW-1:0] rd_addr, wr_addr;

   assign load_ok = !out_valid_ff || rsp_ready;

   always_comb begin
      gap       = 3'(3'd0 - cursor_ff[2:0]);
      is_wr     = (cmd.kind == bgb_pkg::KIND_WRITE) || (cmd.kind == bgb_pkg::KIND_PAD);
      is_rd     = (cmd.kind == bgb_pkg::KIND_READ);
      acc_n     = (cmd.kind == bgb_pkg::KIND_PAD) ? {3'd0, gap} : cmd.count;
      end_acc   = (CW + 1)'(cursor_ff) + (CW + 1)'(acc_n);
      end_skip  = (CW + 1)'(cursor_ff) + (CW + 1)'(gap);
      wr_fit    = (end_acc <= CAP_X);
      rd_fit    = (end_acc <= (CW + 1)'(size_ff));
      goes_access = (is_wr && wr_fit) || (is_rd && rd_fit);
      span_bits = 7'(cursor_ff[2:0]) + 7'(acc_n);
      nmask_cmd = (SB'(1) << acc_n) - SB'(1);
   end

   assign cmd_pop = (state_ff == ST_IDLE) && cmd_valid && (goes_access || load_ok);

   // byte loop datapath
   always_comb begin
      j        = k_ff - KW'(1);
      wdata_sh = wdata_ff >> {j, 3'b000};
      wmask_sh = wmask_ff >> {j, 3'b000};
      dbyte    = wdata_sh[7:0];
      mbyte    = wmask_sh[7:0];
      wbyte    = (rbyte & ~mbyte) | (dbyte & mbyte);
      last     = (k_ff == nbytes_ff);
      rd_en    = (state_ff == ST_ACCESS) && (k_ff < nbytes_ff);
      rd_addr  = AW'(base_ff + AW'(k_ff));
      wr_addr  = AW'(base_ff + AW'(j));
      wr_en    = (state_ff == ST_ACCESS) && !is_read_ff && (k_ff != '0) && (!last || load_ok);
      nmask_run = (SB'(1) << n_ff) - SB'(1);
   end

   bgb_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wbyte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rbyte)
   );

   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      size_in      = size_ff;
      is_read_in   = is_read_ff;
      base_in      = base_ff;
      off_in       = off_ff;
      nbytes_in    = nbytes_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      wdata_in     = wdata_ff;
      wmask_in     = wmask_ff;
      buf_in       = buf_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               if (goes_access) begin
                  state_in   = ST_ACCESS;
                  is_read_in = is_rd;
                  base_in    = AW'(cursor_ff >> 3);
                  off_in     = cursor_ff[2:0];
                  nbytes_in  = (acc_n == 6'd0) ? KW'(0) :
                               KW'(((span_bits - 7'd1) >> 3) + 7'd1);
                  k_in       = '0;
                  n_in       = acc_n;
                  wmask_in   = nmask_cmd << cursor_ff[2:0];
                  wdata_in   = (cmd.kind == bgb_pkg::KIND_PAD) ? '0 :
                               ((SB'(cmd.value) & nmask_cmd) << cursor_ff[2:0]);
                  buf_in     = '0;
                  cursor_in  = CW'(end_acc);
                  if (is_wr && (CW'(end_acc) > size_ff)) begin
                     size_in = CW'(end_acc);
                  end
               end else begin
                  out_in.read_data = '0;
                  out_in.bits_done = '0;
                  out_in.fault     = 1'b0;
                  case (cmd.kind) inside
                     bgb_pkg::KIND_WRITE, bgb_pkg::KIND_PAD, bgb_pkg::KIND_READ: begin
                        out_in.fault = 1'b1;   // only failing accesses land here
                     end
                     bgb_pkg::KIND_CLEAR: begin
                        cursor_in = '0;
                        size_in   = '0;
                     end
                     bgb_pkg::KIND_SKIP: begin
                        if (end_skip > CAP_X) begin
                           cursor_in    = CW'(CAP);
                           out_in.fault = 1'b1;
                        end else begin
                           cursor_in = CW'(end_skip);
                        end
                     end
                     bgb_pkg::KIND_SEEK: begin
                        if ({1'b0, cmd.value} > 33'(CAP)) begin
                           cursor_in    = CW'(CAP);
                           out_in.fault = 1'b1;
                        end else begin
                           cursor_in = CW'(cmd.value);
                        end
                     end
                     default: begin
                     end
                  endcase
                  out_in.cursor_now = bgb_pkg::POS_BITS'(cursor_in);
                  out_in.fill_bits  = bgb_pkg::POS_BITS'(size_in);
                  out_valid_in      = 1'b1;
               end
            end
         end
         ST_ACCESS: begin
            // byte k-1 arrives from the store while byte k is being fetched
            if (k_ff != '0 && is_read_ff) begin
               buf_in = buf_ff | (SB'(rbyte) << {j, 3'b000});
            end
            if (!last) begin
               k_in = k_ff + KW'(1);
            end else if (load_ok) begin
               out_in.read_data  = is_read_ff ? 32'((buf_in >> off_ff) & nmask_run) : '0;
               out_in.bits_done  = n_ff;
               out_in.cursor_now = bgb_pkg::POS_BITS'(cursor_ff);
               out_in.fill_bits  = bgb_pkg::POS_BITS'(size_ff);
               out_in.fault      = 1'b0;
               out_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         size_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         size_ff      <= size_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_read_ff <= is_read_in;
      base_ff    <= base_in;
      off_ff     <= off_in;
      nbytes_ff  <= nbytes_in;
      k_ff       <= k_in;
      n_ff       <= n_in;
      wdata_ff   <= wdata_in;
      wmask_ff   <= wmask_in;
      buf_ff     <= buf_in;
      out_ff     <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

// File: design/bit_granular_buffer.sv
// ----------------------------------------------------------------------------
// bit_granular_buffer
// Byte store with one shared bit cursor: LSB-first field writes and reads,
// clear, pad and skip to byte boundary, and seek.
// ----------------------------------------------------------------------------
// Each request item gives exactly one response item. Clear, skip, seek,
// unused opcodes and failing accesses are answered from the idle state of the
// back end. A write, pad or read that succeeds goes on to the access state,
// which steps through the B store bytes that the field touches (0 to 5 for a
// 32-bit field): the store is a single byte-wide RAM with one read and one
// write port, and each touched byte goes through one read-modify-write (or
// gather) step. A two-entry command queue lets requests be taken while the
// back end works, and the response register lets the next write, pad or read
// start while a response is still waiting. The store needs no initialization
// after reset; reading never-written bits returns unspecified values.
module bit_granular_buffer #(
   parameter int STORE_BYTES    = 4096,
   parameter int MAX_FIELD_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // value[31:0], bit_count[37:32], zero pad
   input  logic [2:0]   req_tuser,   // opcode[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata    // read_data[31:0], bits_done[37:32],
                                     // cursor_now[53:38], fill_bits[69:54],
                                     // fault[70], zero pad
);

   logic              cmd_valid;
   logic              cmd_pop;
   bgb_pkg::cmd_type  cmd;
   bgb_pkg::rsp_type  rsp;

   bgb_front #(
      .MAX_FIELD_BITS (MAX_FIELD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_opcode (req_tuser),
      .req_value  (req_tdata[31:0]),
      .req_count  (req_tdata[37:32]),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   bgb_back #(
      .STORE_BYTES    (STORE_BYTES),
      .MAX_FIELD_BITS (MAX_FIELD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {1'b0, rsp.fault, rsp.fill_bits, rsp.cursor_now,
                       rsp.bits_done, rsp.read_data};

endmodule
